// ----- rtl/wfs_pkg.sv -----
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared constants and word types of the weighted fair scheduler.
// ----------------------------------------------------------------------------
package wfs_pkg;

   localparam logic [1:0] STATUS_PICKED = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_ADDED  = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   localparam logic ACTION_ADD  = 1'b0;
   localparam logic ACTION_PICK = 1'b1;

   localparam logic [7:0] GRAN_DEFAULT = 8'd3;
   localparam logic [30:0] VRT_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0] SLICE_MAX = 16'hFFFF;

   typedef struct packed {
      logic        action;
      logic [7:0]  thread_id;
      logic [1:0]  priority_class;
      logic [16:0] weight;
      logic [15:0] served_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  picked_id;
      logic [15:0] slice_len;
      logic [30:0] picked_vruntime;
      logic [16:0] picked_weight;
   } rsp_type;

   // divider start request and reply
   // divisor covers a 21-bit weight total times a count of up to 256
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [29:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   function automatic logic [16:0] class_weight(input logic [1:0] cls);
      logic [16:0] w;
      case (cls)
         2'd0:    w = 17'd88761;
         2'd1:    w = 17'd29154;
         2'd2:    w = 17'd1024;
         default: w = 17'd15;
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/wfs_if.sv -----
// ----------------------------------------------------------------------------
// wfs_req_if / wfs_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface wfs_req_if;
   logic              valid;
   logic              ready;
   wfs_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wfs_rsp_if;
   logic              valid;
   logic              ready;
   wfs_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/wfs_divider.sv -----
// ----------------------------------------------------------------------------
// wfs_divider
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module wfs_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  wfs_pkg::div_req_type  div_req,
   output wfs_pkg::div_rsp_type  div_rsp
);
   logic [63:0] quo_ff, quo_in;
   logic [30:0] rem_ff, rem_in;
   logic [29:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [30:0] trial;

   // one shift and subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[29:0], quo_ff[63]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule

// ----- rtl/weighted_fair_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// weighted_fair_scheduler_top
// Ready table of a weighted fair scheduler with add and pick requests.
// ----------------------------------------------------------------------------
// Usage: an add word stores a thread with vruntime 1024*service/weight; a
// pick word removes the entry with least vruntime (oldest first on ties) and
// returns its time slice. One response word per request word.
// req is ready only while the sequencer is idle; one word at a time.
// Sequence: every word first scans the table one slot a cycle. An add then
// runs a 64-step division in the shared serial divider before its response
// word is valid; a full table answers straight after the scan. A pick spends
// one more state, ST_MUL, starting the slice division; an empty pick answers
// straight after the scan. The weight-total by count product is registered
// during the scan. req is ready again in the cycle after the response word
// is taken.
// The response sits in an output register until taken; a stalled receiver
// holds the block in its answer state, with req not ready.
// Reset clears valid bits, the weight total, the count, the arrival stamp
// and sets the granularity floor to 3. csr writes land on any enabled edge outside reset.
// ----------------------------------------------------------------------------
module weighted_fair_scheduler_top #(
   parameter int TABLE_DEPTH = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic          clock,
   input  logic          reset,
   wfs_req_if.sink       req,
   wfs_rsp_if.source     rsp,
   input  logic          csr_write_enable,
   input  logic [7:0]    csr_write_data
);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_WAIT = 3'd4;
   localparam logic [2:0] ST_RESP = 3'd5;

   logic [2:0] state_ff, state_in;
   wfs_pkg::req_type req_ff;
   wfs_pkg::rsp_type rsp_ff, rsp_in;
   logic [7:0]  gran_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [7:0]  thr_mem [TABLE_DEPTH];
   logic [16:0] wgt_mem [TABLE_DEPTH];
   logic [30:0] vrt_mem [TABLE_DEPTH];
   logic [15:0] arr_mem [TABLE_DEPTH];
   logic [20:0] wtot_ff;
   logic [CW-1:0] count_ff;
   logic [15:0] arr_ff;
   logic [IW:0] idx_ff;
   logic        found_ff;
   logic [IW-1:0] best_ff;
   logic [30:0] bvrt_ff;
   logic [15:0] bage_ff;
   logic [16:0] bwgt_ff;
   logic [7:0]  bthr_ff;
   logic [IW-1:0] free_ff;
   logic        has_free_ff;
   logic [16:0] rw_ff;
   logic [29:0] denom_ff;
   logic        pick_ff;
   wfs_pkg::div_req_type div_req;
   wfs_pkg::div_rsp_type div_rsp;
   logic [IW-1:0] idx;
   logic [15:0] age;
   logic [16:0] rw;
   logic        better;
   logic [63:0] q;
   logic [63:0] gran_fx;
   logic [63:0] slice;

   wfs_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign idx = idx_ff[IW-1:0];
   assign age = arr_ff - arr_mem[idx];
   assign rw  = (req_ff.weight == 17'd0) ? wfs_pkg::class_weight(req_ff.priority_class)
                                         : req_ff.weight;
   assign better = !found_ff || (vrt_mem[idx] < bvrt_ff) ||
                   (vrt_mem[idx] == bvrt_ff && age > bage_ff);
   assign q = div_rsp.quotient;
   assign gran_fx = {56'd0, (gran_ff == 8'd0) ? wfs_pkg::GRAN_DEFAULT : gran_ff} << FRAC_BITS;
   assign slice = (denom_ff == 30'd0) ? 64'(wfs_pkg::SLICE_MAX) :
                  ((q < gran_fx) ? gran_fx : q);

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_RESP);
   assign rsp.data  = rsp_ff;

   // sequencer next state and divider kick
   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         ST_IDLE: if (req.valid) state_in = ST_SCAN;
         ST_SCAN: begin
            if (idx_ff == (IW + 1)'(TABLE_DEPTH)) begin
               rsp_in = '0;
               if (!pick_ff) begin
                  if (!has_free_ff) begin
                     rsp_in.status = wfs_pkg::STATUS_FULL;
                     state_in = ST_RESP;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = (64'(req_ff.served_ticks) << 10) << FRAC_BITS;
                     div_req.divisor  = 30'(rw);
                     state_in = ST_DIV;
                  end
               end else if (!found_ff) begin
                  rsp_in.status = wfs_pkg::STATUS_EMPTY;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            div_req.start    = 1'b1;
            div_req.dividend = (64'(bwgt_ff) * 64'd48) << FRAC_BITS;
            div_req.divisor  = (denom_ff == 30'd0) ? 30'd1 : denom_ff;
            state_in = ST_DIV;
         end
         ST_DIV: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_rsp.done) begin
               rsp_in = '0;
               if (pick_ff) begin
                  rsp_in.status          = wfs_pkg::STATUS_PICKED;
                  rsp_in.picked_id       = bthr_ff;
                  rsp_in.slice_len       = (slice > 64'(wfs_pkg::SLICE_MAX)) ?
                                           wfs_pkg::SLICE_MAX : slice[15:0];
                  rsp_in.picked_vruntime = bvrt_ff;
                  rsp_in.picked_weight   = bwgt_ff;
               end else begin
                  rsp_in.status = wfs_pkg::STATUS_ADDED;
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // table, scan and bookkeeping registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         wtot_ff  <= '0;
         count_ff <= '0;
         arr_ff   <= '0;
         gran_ff  <= wfs_pkg::GRAN_DEFAULT;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) gran_ff <= csr_write_data;
         if (state_ff == ST_WAIT && div_rsp.done) begin
            if (pick_ff) begin
               valid_ff[best_ff] <= 1'b0;
               wtot_ff  <= wtot_ff - 21'(bwgt_ff);
               count_ff <= count_ff - CW'(1);
            end else begin
               valid_ff[free_ff] <= 1'b1;
               wtot_ff  <= wtot_ff + 21'(rw_ff);
               count_ff <= count_ff + CW'(1);
               arr_ff   <= arr_ff + 16'd1;
            end
         end
      end
      rsp_ff <= rsp_in;
      // accept and clear scan
      if (state_ff == ST_IDLE) begin
         req_ff      <= req.data;
         pick_ff     <= (req.data.action == wfs_pkg::ACTION_PICK);
         idx_ff      <= '0;
         found_ff    <= 1'b0;
         has_free_ff <= 1'b0;
      end
      // one slot per cycle: first free slot and best candidate
      if (state_ff == ST_SCAN && idx_ff != (IW + 1)'(TABLE_DEPTH)) begin
         idx_ff <= idx_ff + (IW + 1)'(1);
         if (!valid_ff[idx] && !has_free_ff) begin
            has_free_ff <= 1'b1;
            free_ff     <= idx;
         end
         if (valid_ff[idx] && better) begin
            found_ff <= 1'b1;
            best_ff  <= idx;
            bvrt_ff  <= vrt_mem[idx];
            bage_ff  <= age;
            bwgt_ff  <= wgt_mem[idx];
            bthr_ff  <= thr_mem[idx];
         end
      end
      if (state_ff == ST_SCAN) begin
         rw_ff    <= rw;
         denom_ff <= 30'(wtot_ff) * 30'(count_ff);
      end
      // clamp vruntime and write the entry
      if (state_ff == ST_WAIT && div_rsp.done && !pick_ff) begin
         thr_mem[free_ff] <= req_ff.thread_id;
         wgt_mem[free_ff] <= rw_ff;
         vrt_mem[free_ff] <= (q > 64'(wfs_pkg::VRT_MAX)) ? wfs_pkg::VRT_MAX : q[30:0];
         arr_mem[free_ff] <= arr_ff;
      end
   end
endmodule
